### rtl/ghist_pkg.sv
package ghist_pkg;

  localparam int PIX_W = 8;
  localparam int CMD_W = 2;
  localparam int IN_DATA_W = 2 * PIX_W;

  localparam int NUM_BINS_DEF = 256;
  localparam int COUNT_WIDTH_DEF = 24;

  localparam logic [PIX_W-1:0] MAX_GRAY_RST = 8'd255;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_ACCUMULATE = 2'd0;
  localparam cmd_t CMD_READ       = 2'd1;
  localparam cmd_t CMD_CLEAR      = 2'd2;

endpackage

### rtl/gray_level_histogram.sv
// channel   | dir | handshake                    | payload
// ----------+-----+------------------------------+------------------------------------
// s_axis    | in  | s_axis_tvalid / s_axis_tready| tuser: command; tdata: pixel, bin
// m_axis    | out | m_axis_tvalid / m_axis_tready| tdata: bin_number, bin_count
// cfg       | in  | cfg_valid_i / cfg_ready_o    | cfg_data_i: max_gray
//
// Accumulate and read run back to back (a read may stall): RAM read at accept, modify and
// write back in the next cycle, with a one-entry write forward for same-bin neighbors.
// Clear sweeps every bin to zero through the one RAM write port.
// After reset the same sweep runs before the first transaction.
// A read result waiting in the output register stalls the pipe only if another read
// must move into it; max_gray resets to 255.
module gray_level_histogram #(
  parameter int NUM_BINS    = ghist_pkg::NUM_BINS_DEF,
  parameter int COUNT_WIDTH = ghist_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [ghist_pkg::IN_DATA_W-1:0]       s_axis_tdata,   // pixel_value, bin_index
  input  logic [ghist_pkg::CMD_W-1:0]           s_axis_tuser,   // command
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((ghist_pkg::PIX_W + COUNT_WIDTH + 7) / 8) * 8 - 1:0]
                                                m_axis_tdata,   // bin_number, bin_count
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ghist_pkg::PIX_W-1:0]           cfg_data_i      // max_gray
);

  import ghist_pkg::*;

  localparam int AW    = $clog2(NUM_BINS);
  localparam int LW    = (AW + 1 > PIX_W) ? AW + 1 : PIX_W;
  localparam int OUT_W = ((PIX_W + COUNT_WIDTH + 7) / 8) * 8;

  logic [PIX_W-1:0]       max_gray_q;
  logic                   in_fire;
  cmd_t                   in_cmd;
  logic [PIX_W-1:0]       in_pix, in_idx, in_level;
  logic                   in_rng;

  logic                   s1_valid_q, s1_valid_d;
  cmd_t                   s1_cmd_q;
  logic [AW-1:0]          s1_addr_q;
  logic [PIX_W-1:0]       s1_num_q;
  logic                   s1_rng_q;

  logic                   fwd_valid_q;
  logic [AW-1:0]          fwd_addr_q;
  logic [COUNT_WIDTH-1:0] fwd_data_q;

  logic [COUNT_WIDTH-1:0] ram_rdata, cur, nxt, rd_count;
  logic                   s1_acc_wr, s1_read, s1_clear, out_free, stall;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;

  logic                   clr_busy;
  logic [AW-1:0]          clr_addr;

  logic                   out_valid_q, out_valid_d;
  logic [OUT_W-1:0]       out_data_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_gray_q <= MAX_GRAY_RST;
    end else if (cfg_valid_i) begin
      max_gray_q <= cfg_data_i;
    end
  end

  assign in_cmd   = s_axis_tuser;
  assign in_pix   = s_axis_tdata[PIX_W-1:0];
  assign in_idx   = s_axis_tdata[2*PIX_W-1:PIX_W];
  assign in_level = (in_cmd == CMD_READ) ? in_idx : in_pix;
  assign in_rng   = (LW'(in_level) <= LW'(max_gray_q)) && (LW'(in_level) < LW'(NUM_BINS));
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  // modify stage
  assign s1_acc_wr = s1_valid_q && (s1_cmd_q == CMD_ACCUMULATE) && s1_rng_q;
  assign s1_read   = s1_valid_q && (s1_cmd_q == CMD_READ);
  assign s1_clear  = s1_valid_q && (s1_cmd_q == CMD_CLEAR);
  assign out_free  = !out_valid_q || m_axis_tready;
  assign stall     = s1_read && !out_free;

  assign cur      = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : ram_rdata;
  assign nxt      = (&cur) ? cur : cur + 1'b1;
  assign rd_count = s1_rng_q ? cur : '0;

  assign s_axis_tready = !clr_busy && !s1_clear && !stall;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (!stall) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q  <= in_cmd;
      s1_addr_q <= AW'(in_level);
      s1_num_q  <= in_idx;
      s1_rng_q  <= in_rng;
    end
  end

  // last write back, covers read-first RAM on the next bin access
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (clr_busy) begin
      fwd_valid_q <= 1'b0;
    end else if (s1_acc_wr) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_acc_wr) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= nxt;
    end
  end

  assign ram_we    = clr_busy || s1_acc_wr;
  assign ram_waddr = clr_busy ? clr_addr : s1_addr_q;
  assign ram_wdata = clr_busy ? '0 : nxt;

  ghist_ram #(
    .Width (COUNT_WIDTH),
    .Depth (NUM_BINS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (AW'(in_level)),
    .rdata_o (ram_rdata)
  );

  ghist_clr #(
    .NumBins (NUM_BINS)
  ) u_clr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (s1_clear),
    .busy_o  (clr_busy),
    .addr_o  (clr_addr)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_read && out_free) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_read && out_free) begin
      out_data_q <= OUT_W'({rd_count, s1_num_q});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !s_axis_tready)
    else $error("transaction accepted during clear sweep");

  a_no_wb_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !s1_valid_q)
    else $error("pipeline active during clear sweep");

  a_clear_starts_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_clear |=> clr_busy)
    else $error("clear did not start sweep");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_acc_wr |-> (nxt != '0))
    else $error("accumulate wrapped a counter");

  a_read_moves_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_read && out_free) |=> m_axis_tvalid)
    else $error("read result not loaded");
`endif

endmodule

### rtl/ghist_ram.sv
module ghist_ram #(
  parameter int Width = 24,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ghist_clr.sv
module ghist_clr #(
  parameter int NumBins = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  output logic [$clog2(NumBins)-1:0] addr_o
);

  localparam int AW = $clog2(NumBins);
  localparam logic [AW-1:0] LAST = AW'(NumBins - 1);

  logic          busy_q, busy_d;
  logic [AW-1:0] cnt_q, cnt_d;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (busy_q) begin
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        cnt_d  = '0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end
  end

  // sweep runs out of reset as well
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  assign busy_o = busy_q;
  assign addr_o = cnt_q;

endmodule
